>>> rtl/buddy_page_allocator_macros.svh
// assertion macros for the buddy page allocator checker
// no dependencies
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("bpa assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("bpa assertion failed");

`endif

>>> rtl/bpa_pkg.sv
// shared types and codes for the buddy page allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOMEM = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FREE  = 7'b0000010,
        S_ABRD  = 7'b0000100,
        S_ABCHK = 7'b0001000,
        S_ALRD  = 7'b0010000,
        S_ALCHK = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

>>> rtl/bpa_map.sv
// free map memory, one bit per buddy tree node, with clearing pass after reset
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module bpa_map #(
    parameter int ADDR_BITS = 10,
    parameter int IDX_W     = ADDR_BITS + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic                  rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic             wr_data,
    output logic                  ready
);
    localparam int DEPTH = (2 << ADDR_BITS) - 1;

    logic             mem [DEPTH];
    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] clr_next;
    logic             rd_data_reg;
    logic             clearing;

    assign clearing = (clr_reg != IDX_W'(DEPTH));
    assign clr_next = clearing ? clr_reg + IDX_W'(1) : clr_reg;
    assign ready    = !clearing;
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> rtl/bpa_index.sv
// shared node index unit: level base plus block offset
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module bpa_index #(
    parameter int ADDR_BITS = 10,
    parameter int IDX_W     = ADDR_BITS + 1,
    parameter int LVL_W     = $clog2(ADDR_BITS + 1)
) (
    input  wire logic [LVL_W-1:0]     lvl,
    input  wire logic [ADDR_BITS-1:0] offset,
    output logic      [IDX_W-1:0]     idx
);
    logic [LVL_W-1:0] sh;
    logic [IDX_W-1:0] base;

    assign sh   = LVL_W'(ADDR_BITS) - lvl;
    assign base = (IDX_W'(1) << sh) - IDX_W'(1);
    assign idx  = base + IDX_W'(offset);
endmodule
`default_nettype wire

>>> rtl/bpa_seq.sv
// request sequencer: allocation scan, range split and buddy merge
// depends on bpa_pkg and bpa_index
`timescale 1ns / 1ps
`default_nettype none
module bpa_seq
    import bpa_pkg::*;
#(
    parameter int ADDR_BITS = 10,
    parameter int IDX_W     = ADDR_BITS + 1,
    parameter int LVL_W     = $clog2(ADDR_BITS + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire logic                 req_action,
    input  wire logic [ADDR_BITS-1:0] req_page,
    input  wire logic [ADDR_BITS:0]   req_count,
    output logic                      res_valid,
    input  wire logic                 res_take,
    output logic      [ADDR_BITS-1:0] res_granted,
    output status_t                   res_status,
    input  wire logic                 map_ready,
    output logic      [IDX_W-1:0]     map_addr,
    input  wire logic                 map_rd_data,
    output logic                      map_wr_en,
    output logic                      map_wr_data
);
    localparam int PW = ADDR_BITS;
    localparam int CW = ADDR_BITS + 1;

    state_t          state_reg, state_next;
    logic [PW-1:0]   rng_page_reg, rng_page_next;
    logic [CW-1:0]   rng_cnt_reg, rng_cnt_next;
    logic [PW-1:0]   cur_pg_reg, cur_pg_next;
    logic [LVL_W-1:0] cur_lvl_reg, cur_lvl_next;
    logic [LVL_W-1:0] blk_lvl_reg, blk_lvl_next;
    logic [PW-1:0]   scan_i_reg, scan_i_next;
    logic [CW-1:0]   req_cnt_reg, req_cnt_next;
    logic [PW-1:0]   blk_reg, blk_next;
    logic            alloc_reg, alloc_next;
    logic [PW-1:0]   granted_reg, granted_next;
    status_t         status_reg, status_next;

    logic [LVL_W-1:0] align, slev, lvl_fit, want;
    logic [PW-1:0]   buddy, offset;
    logic [LVL_W-1:0] idx_lvl;
    logic            use_buddy;
    logic [CW-1:0]   blk_size, scan_size;
    logic [PW-1:0]   scan_last;

    assign req_ready   = (state_reg == S_IDLE) && map_ready;
    assign res_valid   = (state_reg == S_DONE);
    assign res_granted = granted_reg;
    assign res_status  = status_reg;

    always_comb
    begin
        align = LVL_W'(ADDR_BITS);
        for (int b = ADDR_BITS - 1; b >= 0; b--)
        begin
            if (rng_page_reg[b])
            begin
                align = LVL_W'(b);
            end
        end
        slev = '0;
        for (int b = 0; b <= ADDR_BITS; b++)
        begin
            if (rng_cnt_reg[b])
            begin
                slev = LVL_W'(b);
            end
        end
        lvl_fit = (align < slev) ? align : slev;
        want = LVL_W'(ADDR_BITS);
        for (int w = ADDR_BITS; w >= 0; w--)
        begin
            if ((CW'(1) << w) >= req_count)
            begin
                want = LVL_W'(w);
            end
        end
    end

    assign buddy     = cur_pg_reg ^ PW'(CW'(1) << cur_lvl_reg);
    assign blk_size  = CW'(1) << blk_lvl_reg;
    assign scan_size = CW'(1) << cur_lvl_reg;
    assign scan_last = PW'((CW'(1) << (LVL_W'(ADDR_BITS) - cur_lvl_reg)) - CW'(1));
    assign use_buddy = (state_reg == S_ABRD) || ((state_reg == S_ABCHK) && map_rd_data);
    assign idx_lvl   = cur_lvl_reg;

    always_comb
    begin
        if ((state_reg == S_ALRD) || (state_reg == S_ALCHK))
        begin
            offset = scan_i_reg;
        end
        else if (use_buddy)
        begin
            offset = buddy >> cur_lvl_reg;
        end
        else
        begin
            offset = cur_pg_reg >> cur_lvl_reg;
        end
    end

    bpa_index #(
        .ADDR_BITS(ADDR_BITS),
        .IDX_W    (IDX_W),
        .LVL_W    (LVL_W)
    ) u_index (
        .lvl   (idx_lvl),
        .offset(offset),
        .idx   (map_addr)
    );

    always_comb
    begin
        state_next    = state_reg;
        rng_page_next = rng_page_reg;
        rng_cnt_next  = rng_cnt_reg;
        cur_pg_next   = cur_pg_reg;
        cur_lvl_next  = cur_lvl_reg;
        blk_lvl_next  = blk_lvl_reg;
        scan_i_next   = scan_i_reg;
        req_cnt_next  = req_cnt_reg;
        blk_next      = blk_reg;
        alloc_next    = alloc_reg;
        granted_next  = granted_reg;
        status_next   = status_reg;
        map_wr_en     = 1'b0;
        map_wr_data   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    granted_next  = '0;
                    status_next   = ST_DONE;
                    rng_page_next = req_page;
                    rng_cnt_next  = req_count;
                    req_cnt_next  = req_count;
                    alloc_next    = !req_action;
                    scan_i_next   = '0;
                    cur_lvl_next  = want;
                    if (req_count == '0)
                    begin
                        status_next = ST_BAD;
                        state_next  = S_DONE;
                    end
                    else if (req_action)
                    begin
                        if (({1'b0, req_page} + CW'(req_count)) > (CW + 1)'(CW'(1) << ADDR_BITS))
                        begin
                            status_next = ST_BAD;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                    else if (req_count > (CW'(1) << ADDR_BITS))
                    begin
                        status_next = ST_BAD;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ALRD;
                    end
                end
            end
            S_FREE:
            begin
                if (rng_cnt_reg == '0)
                begin
                    if (alloc_reg)
                    begin
                        granted_next = blk_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cur_pg_next  = rng_page_reg;
                    cur_lvl_next = lvl_fit;
                    blk_lvl_next = lvl_fit;
                    state_next   = S_ABRD;
                end
            end
            S_ABRD:
            begin
                if (cur_lvl_reg == LVL_W'(ADDR_BITS))
                begin
                    map_wr_en     = 1'b1;
                    map_wr_data   = 1'b1;
                    rng_page_next = rng_page_reg + PW'(blk_size);
                    rng_cnt_next  = rng_cnt_reg - blk_size;
                    state_next    = S_FREE;
                end
                else
                begin
                    state_next = S_ABCHK;
                end
            end
            S_ABCHK:
            begin
                map_wr_en = 1'b1;
                if (map_rd_data)
                begin
                    map_wr_data  = 1'b0;
                    cur_pg_next  = cur_pg_reg & ~PW'(CW'(1) << cur_lvl_reg);
                    cur_lvl_next = cur_lvl_reg + LVL_W'(1);
                    state_next   = S_ABRD;
                end
                else
                begin
                    map_wr_data   = 1'b1;
                    rng_page_next = rng_page_reg + PW'(blk_size);
                    rng_cnt_next  = rng_cnt_reg - blk_size;
                    state_next    = S_FREE;
                end
            end
            S_ALRD:
            begin
                state_next = S_ALCHK;
            end
            S_ALCHK:
            begin
                if (map_rd_data)
                begin
                    map_wr_en   = 1'b1;
                    map_wr_data = 1'b0;
                    blk_next    = scan_i_reg << cur_lvl_reg;
                    if (scan_size > req_cnt_reg)
                    begin
                        rng_page_next = (scan_i_reg << cur_lvl_reg) + PW'(req_cnt_reg);
                        rng_cnt_next  = scan_size - req_cnt_reg;
                        state_next    = S_FREE;
                    end
                    else
                    begin
                        granted_next = scan_i_reg << cur_lvl_reg;
                        state_next   = S_DONE;
                    end
                end
                else if (scan_i_reg == scan_last)
                begin
                    if (cur_lvl_reg == LVL_W'(ADDR_BITS))
                    begin
                        status_next = ST_NOMEM;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cur_lvl_next = cur_lvl_reg + LVL_W'(1);
                        scan_i_next  = '0;
                        state_next   = S_ALRD;
                    end
                end
                else
                begin
                    scan_i_next = scan_i_reg + PW'(1);
                    state_next  = S_ALRD;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rng_page_reg <= rng_page_next;
        rng_cnt_reg  <= rng_cnt_next;
        cur_pg_reg   <= cur_pg_next;
        cur_lvl_reg  <= cur_lvl_next;
        blk_lvl_reg  <= blk_lvl_next;
        scan_i_reg   <= scan_i_next;
        req_cnt_reg  <= req_cnt_next;
        blk_reg      <= blk_next;
        alloc_reg    <= alloc_next;
        granted_reg  <= granted_next;
        status_reg   <= status_next;
    end
endmodule
`default_nettype wire

>>> rtl/buddy_page_allocator.sv
// buddy page allocator top level: sequencer, free map and output register
// depends on bpa_pkg, bpa_seq, bpa_map
`timescale 1ns / 1ps
`default_nettype none
// One request at a time; every request gives one result. Each read of the free map
// goes through its single registered read port. An allocation reads one tree node
// at a time, from the smallest level that fits the count upward. A free cuts the
// range into blocks and merges each block with its buddy, level by level, while
// the buddy is free. A full scan covers the 2^(ADDR_BITS+1)-1 nodes. After reset a
// clearing pass over all 2^(ADDR_BITS+1)-1 nodes (2047 by default) empties the pool,
// and no input transfer is taken until it ends. The result sits in an output
// register, so the next request is taken while it waits.
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int ADDR_BITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 action,
    input  wire logic [ADDR_BITS-1:0] block_page,
    input  wire logic [ADDR_BITS:0]   page_count,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [ADDR_BITS-1:0] granted_page,
    output logic      [1:0]           status
);
    localparam int IDX_W = ADDR_BITS + 1;

    logic                 req_ready;
    logic                 res_valid;
    logic                 res_take;
    logic [ADDR_BITS-1:0] res_granted;
    status_t              res_status;
    logic                 map_ready;
    logic [IDX_W-1:0]     map_addr;
    logic                 map_rd_data;
    logic                 map_wr_en;
    logic                 map_wr_data;
    logic                 out_valid_reg;
    logic [ADDR_BITS-1:0] granted_reg;
    status_t              status_reg;

    assign in_stall     = !req_ready;
    assign res_take     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign granted_page = granted_reg;
    assign status       = status_reg;

    bpa_seq #(
        .ADDR_BITS(ADDR_BITS),
        .IDX_W    (IDX_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_valid),
        .req_ready  (req_ready),
        .req_action (action),
        .req_page   (block_page),
        .req_count  (page_count),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res_granted(res_granted),
        .res_status (res_status),
        .map_ready  (map_ready),
        .map_addr   (map_addr),
        .map_rd_data(map_rd_data),
        .map_wr_en  (map_wr_en),
        .map_wr_data(map_wr_data)
    );

    bpa_map #(
        .ADDR_BITS(ADDR_BITS),
        .IDX_W    (IDX_W)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_addr(map_addr),
        .rd_data(map_rd_data),
        .wr_en  (map_wr_en),
        .wr_addr(map_addr),
        .wr_data(map_wr_data),
        .ready  (map_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            granted_reg <= res_granted;
            status_reg  <= res_status;
        end
    end
endmodule
`default_nettype wire

>>> rtl/bpa_checker.sv
// port-level checks for the buddy page allocator, bound to the top level
// depends on bpa_pkg and buddy_page_allocator_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_page_allocator_macros.svh"
module bpa_checker
    import bpa_pkg::*;
#(
    parameter int ADDR_BITS = 10
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic                 action,
    input wire logic [ADDR_BITS-1:0] block_page,
    input wire logic [ADDR_BITS:0]   page_count,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [ADDR_BITS-1:0] granted_page,
    input wire logic [1:0]           status
);
    logic in_xfer;
    logic free_ok;

    assign in_xfer = in_valid && !in_stall;
    assign free_ok = action || (status != ST_DONE);

    `BPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `BPA_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, in_stall)
    `BPA_ASSERT_SAME(a_fail_no_grant, clk, rst_n, out_valid && free_ok && status != ST_DONE, granted_page == '0)
    `BPA_ASSERT_SAME(a_status_code, clk, rst_n, out_valid, status != 2'd3)
endmodule

bind buddy_page_allocator bpa_checker #(.ADDR_BITS(ADDR_BITS)) u_bpa_checker (.*);
`default_nettype wire
